[rtl/imu_rs_pkg.sv]
`timescale 1ns / 1ps

package imu_rs_pkg;

    localparam int GRID_RATE_HZ = 200;
    localparam int MAX_BURST    = 16;
    localparam int OUT_LIMIT    = 16;
    localparam int US_PER_S     = 1000000;

    localparam int NUM_CH  = 6;
    localparam int WEEK_W  = 16;
    localparam int TIME_W  = 40;
    localparam int CH_W    = 32;
    localparam int FRAC_W  = 16;
    localparam int Q16_ONE = 1 << FRAC_W;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int DIFF_W  = CH_W + 1;
    localparam int ACC_W   = DIFF_W + WGT_W;

    localparam int LIMIT   = (MAX_BURST < OUT_LIMIT) ? MAX_BURST : OUT_LIMIT;
    localparam int BURST_W = $clog2(LIMIT + 1);

    localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 64'd1;
    localparam longint unsigned IDX_MAX  =
        (TIME_MAX * longint'(GRID_RATE_HZ)) / longint'(US_PER_S);
    localparam int IDX_W = $clog2(IDX_MAX + 64'd1);

    localparam bit GRID_EXACT = (US_PER_S % GRID_RATE_HZ) == 0;
    localparam int PERIOD_US  = US_PER_S / GRID_RATE_HZ;

    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(TIME_W + 1);
    localparam int MAC_CNT_W = $clog2(WGT_W + 1);

    typedef logic signed [CH_W-1:0]   t_ch;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic                 start;
        logic [TIME_W-1:0]    rem;
        logic [DIV_W-1:0]     num;
        logic [TIME_W-1:0]    dvs;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [WGT_W-1:0] c0;
    } t_mac_req;

endpackage

[rtl/imu_rs_if.sv]
`timescale 1ns / 1ps

interface imu_rs_in_if;
    logic                                valid;
    logic                                ready;
    logic [imu_rs_pkg::WEEK_W-1:0]       gps_week;
    logic [imu_rs_pkg::TIME_W-1:0]       sample_time_us;
    logic signed [imu_rs_pkg::CH_W-1:0]  gyro_x_in;
    logic signed [imu_rs_pkg::CH_W-1:0]  gyro_y_in;
    logic signed [imu_rs_pkg::CH_W-1:0]  gyro_z_in;
    logic signed [imu_rs_pkg::CH_W-1:0]  accel_x_in;
    logic signed [imu_rs_pkg::CH_W-1:0]  accel_y_in;
    logic signed [imu_rs_pkg::CH_W-1:0]  accel_z_in;

    modport source (
        output valid, gps_week, sample_time_us, gyro_x_in, gyro_y_in, gyro_z_in,
               accel_x_in, accel_y_in, accel_z_in,
        input  ready
    );
    modport sink (
        input  valid, gps_week, sample_time_us, gyro_x_in, gyro_y_in, gyro_z_in,
               accel_x_in, accel_y_in, accel_z_in,
        output ready
    );
endinterface

interface imu_rs_out_if;
    logic                                valid;
    logic                                ready;
    logic [imu_rs_pkg::WEEK_W-1:0]       out_week;
    logic [imu_rs_pkg::TIME_W-1:0]       grid_time_us;
    logic signed [imu_rs_pkg::CH_W-1:0]  gyro_x_out;
    logic signed [imu_rs_pkg::CH_W-1:0]  gyro_y_out;
    logic signed [imu_rs_pkg::CH_W-1:0]  gyro_z_out;
    logic signed [imu_rs_pkg::CH_W-1:0]  accel_x_out;
    logic signed [imu_rs_pkg::CH_W-1:0]  accel_y_out;
    logic signed [imu_rs_pkg::CH_W-1:0]  accel_z_out;
    logic                                burst_last;
    logic                                burst_truncated;

    modport source (
        output valid, out_week, grid_time_us, gyro_x_out, gyro_y_out, gyro_z_out,
               accel_x_out, accel_y_out, accel_z_out, burst_last, burst_truncated,
        input  ready
    );
    modport sink (
        input  valid, out_week, grid_time_us, gyro_x_out, gyro_y_out, gyro_z_out,
               accel_x_out, accel_y_out, accel_z_out, burst_last, burst_truncated,
        output ready
    );
endinterface

[rtl/imu_rs_div.sv]
`timescale 1ns / 1ps

module imu_rs_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imu_rs_pkg::t_div_req i_req,
    output imu_rs_pkg::t_div_rsp o_rsp
);

    logic                                r_busy;
    logic [imu_rs_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [imu_rs_pkg::TIME_W-1:0]       r_rem;
    logic [imu_rs_pkg::DIV_W-1:0]        r_num;
    logic [imu_rs_pkg::TIME_W-1:0]       r_quo;
    logic [imu_rs_pkg::TIME_W-1:0]       r_dvs;

    logic [imu_rs_pkg::TIME_W:0]         shifted;
    logic [imu_rs_pkg::TIME_W+1:0]       trial;
    logic                                ge;

    // restoring division, one quotient bit per cycle
    assign shifted = {r_rem, r_num[imu_rs_pkg::DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_dvs};
    assign ge      = ~trial[imu_rs_pkg::TIME_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.steps;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_num <= i_req.num;
            r_dvs <= i_req.dvs;
            r_quo <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= ge ? trial[imu_rs_pkg::TIME_W-1:0] : shifted[imu_rs_pkg::TIME_W-1:0];
            r_num <= {r_num[imu_rs_pkg::DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[imu_rs_pkg::TIME_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quot = r_quo;

endmodule

[rtl/imu_rs_mac.sv]
`timescale 1ns / 1ps

module imu_rs_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imu_rs_pkg::t_mac_req i_req,
    input  imu_rs_pkg::t_ch      i_prev [imu_rs_pkg::NUM_CH],
    input  imu_rs_pkg::t_diff    i_diff [imu_rs_pkg::NUM_CH],
    output logic                 o_done,
    output imu_rs_pkg::t_ch      o_res  [imu_rs_pkg::NUM_CH]
);

    logic                                r_busy;
    logic                                r_done;
    logic [imu_rs_pkg::MAC_CNT_W-1:0]    r_cnt;
    logic [imu_rs_pkg::WGT_W-1:0]        r_c0;
    imu_rs_pkg::t_acc                    r_acc [imu_rs_pkg::NUM_CH];
    imu_rs_pkg::t_ch                     r_res [imu_rs_pkg::NUM_CH];

    imu_rs_pkg::t_acc                    rnd   [imu_rs_pkg::NUM_CH];
    imu_rs_pkg::t_ch                     n_res [imu_rs_pkg::NUM_CH];

    // out = prev + round(c0 * (new - prev) / 2^16), weight taken MSB first
    always_comb begin
        for (int k = 0; k < imu_rs_pkg::NUM_CH; k++) begin
            rnd[k]   = r_acc[k] + imu_rs_pkg::ACC_W'(imu_rs_pkg::Q16_ONE / 2);
            n_res[k] = i_prev[k] + imu_rs_pkg::CH_W'(rnd[k] >>> imu_rs_pkg::FRAC_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= imu_rs_pkg::MAC_CNT_W'(imu_rs_pkg::WGT_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_c0 <= i_req.c0;
            for (int k = 0; k < imu_rs_pkg::NUM_CH; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_busy && (r_cnt != '0)) begin
            r_c0 <= {r_c0[imu_rs_pkg::WGT_W-2:0], 1'b0};
            for (int k = 0; k < imu_rs_pkg::NUM_CH; k++) begin
                r_acc[k] <= (r_acc[k] <<< 1)
                          + (r_c0[imu_rs_pkg::WGT_W-1] ? imu_rs_pkg::ACC_W'(i_diff[k]) : '0);
            end
        end else if (r_busy) begin
            for (int k = 0; k < imu_rs_pkg::NUM_CH; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[rtl/imu_linear_resampler.sv]
`timescale 1ns / 1ps
// Port     Dir  Handshake            Carries
// i_samp   in   valid/ready (sink)   week, time (us), three gyro, three accel
// o_grid   out  valid/ready (source) week, grid time, six channels, last, truncated
//
// A request runs the accept and the 28-step bit-serial grid index divide, then for
// each of the k grid points emitted (k = 0..16) the weight divide and the 17-step
// serial interpolation, with a grid time divide first when the grid period is not a
// whole number of microseconds. Synchronous active-low reset clears the state and
// the valid flags. A full output register stalls only the final load of each point.

module imu_linear_resampler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    imu_rs_in_if.sink     i_samp,
    imu_rs_out_if.source  o_grid
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_IDX  = 8'b0000_0010,
        S_GRID = 8'b0000_0100,
        S_GDIV = 8'b0000_1000,
        S_WGO  = 8'b0001_0000,
        S_WDIV = 8'b0010_0000,
        S_MAC  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state                               r_state, n_state;

    logic [imu_rs_pkg::WEEK_W-1:0]        r_week;
    logic [imu_rs_pkg::TIME_W-1:0]        r_t_new;
    imu_rs_pkg::t_ch                      r_cur     [imu_rs_pkg::NUM_CH];
    logic                                 r_have_prev;
    logic [imu_rs_pkg::TIME_W-1:0]        r_t_prev;
    logic [imu_rs_pkg::IDX_W-1:0]         r_prev_idx;
    imu_rs_pkg::t_ch                      r_prev_ch [imu_rs_pkg::NUM_CH];
    logic [imu_rs_pkg::IDX_W-1:0]         r_n_new;
    logic [imu_rs_pkg::TIME_W-1:0]        r_dt;
    imu_rs_pkg::t_diff                    r_diff    [imu_rs_pkg::NUM_CH];
    logic [imu_rs_pkg::BURST_W-1:0]       r_emit;
    logic [imu_rs_pkg::BURST_W-1:0]       r_i;
    logic                                 r_trunc;
    logic [imu_rs_pkg::TIME_W-1:0]        r_g;

    logic                                 r_out_valid;
    logic [imu_rs_pkg::WEEK_W-1:0]        r_out_week;
    logic [imu_rs_pkg::TIME_W-1:0]        r_out_time;
    imu_rs_pkg::t_ch                      r_out_ch  [imu_rs_pkg::NUM_CH];
    logic                                 r_out_last;
    logic                                 r_out_trunc;

    imu_rs_pkg::t_div_req                 div_req;
    imu_rs_pkg::t_div_rsp                 div_rsp;
    imu_rs_pkg::t_mac_req                 mac_req;
    logic                                 mac_done;
    imu_rs_pkg::t_ch                      mac_res   [imu_rs_pkg::NUM_CH];

    logic                                 accept;
    logic                                 can_load;
    logic                                 go;
    logic                                 is_last;
    logic [imu_rs_pkg::IDX_W-1:0]         n_idx;
    logic [imu_rs_pkg::IDX_W-1:0]         total;
    logic [imu_rs_pkg::IDX_W-1:0]         n_cur;
    logic [imu_rs_pkg::TIME_W-1:0]        off_raw;
    logic [imu_rs_pkg::TIME_W-1:0]        off;
    logic [imu_rs_pkg::DIV_W-1:0]         wgt_num;

    function automatic imu_rs_pkg::t_div_req div_load(
        input logic [imu_rs_pkg::DIV_W-1:0]  num,
        input logic [imu_rs_pkg::TIME_W-1:0] dvs,
        input int                            steps
    );
        imu_rs_pkg::t_div_req req;
        req.start = 1'b1;
        req.rem   = imu_rs_pkg::TIME_W'(num >> steps);
        req.num   = num << (imu_rs_pkg::DIV_W - steps);
        req.dvs   = dvs;
        req.steps = imu_rs_pkg::DIV_CNT_W'(steps);
        return req;
    endfunction

    assign accept   = i_samp.valid && (r_state == S_IDLE);
    assign can_load = !r_out_valid || o_grid.ready;
    assign n_idx    = div_rsp.quot[imu_rs_pkg::IDX_W-1:0];
    assign total    = n_idx - r_prev_idx;
    assign go       = r_have_prev && (r_t_new > r_t_prev) && (n_idx != r_prev_idx);
    assign n_cur    = r_n_new - imu_rs_pkg::IDX_W'(r_i);
    assign is_last  = (r_i + imu_rs_pkg::BURST_W'(1)) == r_emit;
    assign off_raw  = (r_g > r_t_prev) ? (r_g - r_t_prev) : '0;
    assign off      = (off_raw > r_dt) ? r_dt : off_raw;
    assign wgt_num  = (imu_rs_pkg::DIV_W'(off) << imu_rs_pkg::FRAC_W)
                    + imu_rs_pkg::DIV_W'(r_dt >> 1);

    always_comb begin
        n_state       = r_state;
        div_req       = '0;
        mac_req.start = 1'b0;
        mac_req.c0    = (div_rsp.quot > imu_rs_pkg::TIME_W'(imu_rs_pkg::Q16_ONE))
                      ? imu_rs_pkg::WGT_W'(imu_rs_pkg::Q16_ONE)
                      : div_rsp.quot[imu_rs_pkg::WGT_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    div_req = div_load(
                        imu_rs_pkg::DIV_W'(i_samp.sample_time_us)
                            * imu_rs_pkg::DIV_W'(imu_rs_pkg::GRID_RATE_HZ),
                        imu_rs_pkg::TIME_W'(imu_rs_pkg::US_PER_S),
                        imu_rs_pkg::IDX_W);
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                if (div_rsp.done) begin
                    n_state = go ? S_GRID : S_IDLE;
                end
            end
            S_GRID: begin
                if (imu_rs_pkg::GRID_EXACT) begin
                    n_state = S_WGO;
                end else begin
                    div_req = div_load(
                        imu_rs_pkg::DIV_W'(n_cur) * imu_rs_pkg::DIV_W'(imu_rs_pkg::US_PER_S),
                        imu_rs_pkg::TIME_W'(imu_rs_pkg::GRID_RATE_HZ),
                        imu_rs_pkg::TIME_W);
                    n_state = S_GDIV;
                end
            end
            S_GDIV: begin
                if (div_rsp.done) begin
                    n_state = S_WGO;
                end
            end
            S_WGO: begin
                div_req = div_load(wgt_num, r_dt, imu_rs_pkg::WGT_W);
                n_state = S_WDIV;
            end
            S_WDIV: begin
                if (div_rsp.done) begin
                    mac_req.start = 1'b1;
                    n_state       = S_MAC;
                end
            end
            S_MAC: begin
                if (mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    n_state = is_last ? S_IDLE : S_GRID;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDX) && div_rsp.done && !go) begin
                r_have_prev <= 1'b1;
            end
            if ((r_state == S_EMIT) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_grid.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_week   <= i_samp.gps_week;
            r_t_new  <= i_samp.sample_time_us;
            r_cur[0] <= i_samp.gyro_x_in;
            r_cur[1] <= i_samp.gyro_y_in;
            r_cur[2] <= i_samp.gyro_z_in;
            r_cur[3] <= i_samp.accel_x_in;
            r_cur[4] <= i_samp.accel_y_in;
            r_cur[5] <= i_samp.accel_z_in;
        end

        if ((r_state == S_IDX) && div_rsp.done) begin
            if (go) begin
                r_n_new <= n_idx;
                r_dt    <= r_t_new - r_t_prev;
                r_i     <= '0;
                r_trunc <= total > imu_rs_pkg::IDX_W'(imu_rs_pkg::LIMIT);
                r_emit  <= (total < imu_rs_pkg::IDX_W'(imu_rs_pkg::LIMIT))
                         ? total[imu_rs_pkg::BURST_W-1:0]
                         : imu_rs_pkg::BURST_W'(imu_rs_pkg::LIMIT);
                for (int k = 0; k < imu_rs_pkg::NUM_CH; k++) begin
                    r_diff[k] <= imu_rs_pkg::DIFF_W'(r_cur[k])
                               - imu_rs_pkg::DIFF_W'(r_prev_ch[k]);
                end
            end else begin
                r_t_prev   <= r_t_new;
                r_prev_idx <= n_idx;
                r_prev_ch  <= r_cur;
            end
        end

        if (r_state == S_GRID && imu_rs_pkg::GRID_EXACT) begin
            r_g <= imu_rs_pkg::TIME_W'(imu_rs_pkg::DIV_W'(n_cur)
                                       * imu_rs_pkg::DIV_W'(imu_rs_pkg::PERIOD_US));
        end else if ((r_state == S_GDIV) && div_rsp.done) begin
            r_g <= div_rsp.quot;
        end

        if ((r_state == S_EMIT) && can_load) begin
            r_out_week  <= r_week;
            r_out_time  <= r_g;
            r_out_ch    <= mac_res;
            r_out_last  <= is_last;
            r_out_trunc <= r_trunc;
            if (is_last) begin
                r_t_prev   <= r_t_new;
                r_prev_idx <= r_n_new;
                r_prev_ch  <= r_cur;
            end else begin
                r_i <= r_i + imu_rs_pkg::BURST_W'(1);
            end
        end
    end

    imu_rs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    imu_rs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .i_prev  (r_prev_ch),
        .i_diff  (r_diff),
        .o_done  (mac_done),
        .o_res   (mac_res)
    );

    assign i_samp.ready           = (r_state == S_IDLE);
    assign o_grid.valid           = r_out_valid;
    assign o_grid.out_week        = r_out_week;
    assign o_grid.grid_time_us    = r_out_time;
    assign o_grid.gyro_x_out      = r_out_ch[0];
    assign o_grid.gyro_y_out      = r_out_ch[1];
    assign o_grid.gyro_z_out      = r_out_ch[2];
    assign o_grid.accel_x_out     = r_out_ch[3];
    assign o_grid.accel_y_out     = r_out_ch[4];
    assign o_grid.accel_z_out     = r_out_ch[5];
    assign o_grid.burst_last      = r_out_last;
    assign o_grid.burst_truncated = r_out_trunc;

endmodule

[rtl/imu_rs_checker.sv]
`timescale 1ns / 1ps

module imu_rs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_last,
    input logic [imu_rs_pkg::TIME_W-1:0] i_out_time
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_time) && $stable(i_out_last))
        else $error("output request changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before index divide");

    a_burst_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input taken in the middle of a burst");

endmodule

bind imu_linear_resampler imu_rs_checker u_imu_rs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_samp.valid),
    .i_in_ready  (i_samp.ready),
    .i_out_valid (o_grid.valid),
    .i_out_ready (o_grid.ready),
    .i_out_last  (o_grid.burst_last),
    .i_out_time  (o_grid.grid_time_us)
);
